>>> hdl/mrtu_pkg.sv
`default_nettype none

package mrtu_pkg;

  localparam int COUNT_W = 5;

  // outcome codes
  localparam logic [2:0] OUT_READ_BITS_1 = 3'd0;
  localparam logic [2:0] OUT_READ_BITS_2 = 3'd1;
  localparam logic [2:0] OUT_READ_REGS   = 3'd2;
  localparam logic [2:0] OUT_ILL_FUNC    = 3'd3;
  localparam logic [2:0] OUT_ILL_ADDR    = 3'd4;

  // function codes
  localparam logic [7:0] FN_READ_COILS  = 8'd1;
  localparam logic [7:0] FN_READ_INPUTS = 8'd2;
  localparam logic [7:0] FN_READ_REGS   = 8'd3;

  localparam logic [COUNT_W-1:0] WRAP_LIMIT = 5'd20;
  localparam logic [COUNT_W-1:0] MIN_BYTES  = 5'd3;
  localparam logic [2:0]         RESTART_TICKS = 3'd3;
  localparam logic [2:0]         CLOSE_TICKS   = 3'd4;
  localparam logic [2:0]         MAX_GAP       = 3'd5;
  localparam logic [7:0]         ADDR_LIMIT = 8'd48;
  localparam logic [7:0]         MAX_REGS   = 8'd9;
  localparam logic [15:0]        CRC_INIT   = 16'hFFFF;
  localparam logic [15:0]        CRC_POLY   = 16'hA001;

  // checked frame handed from front to back
  typedef struct packed {
    logic [7:0] fn;
    logic [7:0] start;
    logic [7:0] qty;
  } req_t;

  // crc-16/modbus, reflected, one byte
  function automatic logic [15:0] crc_absorb(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/mrtu_front.sv
`default_nettype none

module mrtu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic          op,
  input  logic [7:0]    data_byte,
  input  logic [7:0]    station_address,
  output logic          push,
  output mrtu_pkg::req_t push_req
);
  import mrtu_pkg::*;

  logic [COUNT_W-1:0] byte_count, byte_count_next, cnt0;
  logic [2:0]         gap_ticks, gap_ticks_next, gap_inc;
  logic               timer_armed, timer_armed_next;
  logic [15:0]        running_crc, running_crc_next, crc_base;
  logic [7:0]         byte0, byte1, byte3, byte5;
  logic               closing;

  always_comb begin
    cnt0 = byte_count;
    if (gap_ticks >= RESTART_TICKS && gap_ticks <= CLOSE_TICKS) begin
      cnt0 = '0;
    end
    if (cnt0 > WRAP_LIMIT) begin
      cnt0 = '0;
    end
    crc_base = (cnt0 == '0) ? CRC_INIT : running_crc;
    gap_inc  = gap_ticks + 3'd1;
    closing  = take && op && timer_armed && (gap_inc > CLOSE_TICKS) && (byte_count != '0);

    byte_count_next  = byte_count;
    gap_ticks_next   = gap_ticks;
    timer_armed_next = timer_armed;
    running_crc_next = running_crc;
    if (take && !op) begin
      byte_count_next  = cnt0 + 5'd1;
      running_crc_next = crc_absorb(crc_base, data_byte);
      gap_ticks_next   = '0;
      timer_armed_next = 1'b1;
    end else if (take && timer_armed) begin
      gap_ticks_next = gap_inc;
      if (closing) begin
        byte_count_next  = '0;
        running_crc_next = CRC_INIT;
        timer_armed_next = 1'b0;
      end
    end
  end

  // station, length and crc checked here; only passing frames go on
  assign push = closing && (byte0 == station_address) && (byte_count > MIN_BYTES)
                && (running_crc == 16'd0);
  assign push_req = '{fn: byte1, start: byte3, qty: byte5};

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      gap_ticks   <= '0;
      timer_armed <= 1'b0;
      running_crc <= CRC_INIT;
    end else begin
      byte_count  <= byte_count_next;
      gap_ticks   <= gap_ticks_next;
      timer_armed <= timer_armed_next;
      running_crc <= running_crc_next;
    end
  end

  // only the header bytes the station check and the decoder look at are kept
  always_ff @(posedge clk) begin
    if (take && !op) begin
      if (cnt0 == 5'd0) byte0 <= data_byte;
      if (cnt0 == 5'd1) byte1 <= data_byte;
      if (cnt0 == 5'd3) byte3 <= data_byte;
      if (cnt0 == 5'd5) byte5 <= data_byte;
    end
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !timer_armed |-> byte_count == '0) else $error("disarmed timer with open frame");
  a_gap_bound: assert property (@(posedge clk) disable iff (rst)
    gap_ticks <= MAX_GAP) else $error("gap counter ran past close");
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    closing |=> (byte_count == '0 && running_crc == CRC_INIT))
    else $error("frame not cleared after close");

endmodule

`default_nettype wire

>>> hdl/mrtu_fifo.sv
`default_nettype none

module mrtu_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mrtu_pkg::req_t push_req,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output mrtu_pkg::req_t head
);
  import mrtu_pkg::*;

  req_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_req;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> hdl/mrtu_back.sv
`default_nettype none

module mrtu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  mrtu_pkg::req_t req,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [2:0]     outcome,
  output logic [7:0]     function_code,
  output logic [7:0]     start_address,
  output logic [7:0]     quantity
);
  import mrtu_pkg::*;

  logic [2:0] code;
  logic [7:0] start_adj;
  logic       keep;

  always_comb begin
    code      = OUT_ILL_FUNC;
    start_adj = req.start;
    keep      = 1'b1;
    if (req.start >= ADDR_LIMIT) begin
      code = OUT_ILL_ADDR;
    end else begin
      unique case (req.fn)
        FN_READ_COILS:  code = OUT_READ_BITS_1;
        FN_READ_INPUTS: code = OUT_READ_BITS_2;
        FN_READ_REGS: begin
          code      = OUT_READ_REGS;
          start_adj = req.start - 8'd1;
          keep      = (req.qty <= MAX_REGS);
        end
        default:        code = OUT_ILL_FUNC;
      endcase
    end
  end

  // output register frees when empty or when its beat is taken
  assign pop = req_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= keep;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      outcome       <= code;
      function_code <= req.fn;
      start_address <= start_adj;
      quantity      <= req.qty;
    end
  end

  a_pop_needs_room: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!out_valid || !out_stall)) else $error("pop over a held result");
  a_drop_large_read: assert property (@(posedge clk) disable iff (rst)
    (pop && req.fn == FN_READ_REGS && req.start < ADDR_LIMIT && req.qty > MAX_REGS)
    |=> !out_valid) else $error("oversize register read emitted");
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outcome <= OUT_ILL_ADDR) else $error("bad outcome code");

endmodule

`default_nettype wire

>>> hdl/modbus_rtu_frame_receiver_core.sv
// path: a frame that passes its checks on the closing tick is written into the queue, then
//   popped into the output register when that register is free
// throughput: one byte or tick beat per cycle; in_stall rises only when the two-entry
//   queue between the front end and the decoder is full behind a stalled output
// reset: synchronous active-high rst empties the frame, disarms the gap timer,
//   sets the crc to all ones, empties the queue and loads station address 1
`default_nettype none

module modbus_rtu_frame_receiver_core (
  input  logic       clk,
  input  logic       rst,
  // byte / tick input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [7:0] data_byte,
  // station address write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  // decoded request output
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] outcome,
  output logic [7:0] function_code,
  output logic [7:0] start_address,
  output logic [7:0] quantity
);
  import mrtu_pkg::*;

  logic [7:0] station_address;
  logic       take;
  logic       push, pop, full, not_empty;
  req_t       push_req, head;

  // station register, to be written only while idle; the block itself does not enforce this
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      station_address <= cfg_data;
    end
  end

  // the front end takes a beat whenever the queue has room for a possible close
  assign in_stall = full;
  assign take     = in_valid && !in_stall;

  // front end: gap timer, byte counter, crc and header capture
  mrtu_front u_front (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .op              (op),
    .data_byte       (data_byte),
    .station_address (station_address),
    .push            (push),
    .push_req        (push_req)
  );

  // two-entry queue of checked frames
  mrtu_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_req  (push_req),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  // back end: function decode and output register
  mrtu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (not_empty),
    .req           (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .outcome       (outcome),
    .function_code (function_code),
    .start_address (start_address),
    .quantity      (quantity)
  );

endmodule

`default_nettype wire
